[rtl/lsfe_pkg.sv]
// Package with the constants and the command type shared by the LED frame encoder.
`default_nettype none

package lsfe_pkg;

    localparam int MAX_LEDS       = 256;
    localparam int COLOR_W        = 8;
    localparam int BRIGHT_W       = 5;
    localparam int BYTE_W         = 8;
    localparam int END_ZEROS_BASE = 5;
    localparam int END_ZEROS_DIV  = 16;

    // The LED counter must be able to hold MAX_LEDS itself.
    localparam int CNT_W  = $clog2(MAX_LEDS + 1);
    // Width of the end frame zero count and of the back end byte counter.
    localparam int ZERO_W = $clog2(END_ZEROS_BASE + MAX_LEDS / END_ZEROS_DIV + 1);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hE0;
    localparam logic [BYTE_W-1:0] END_MARK    = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    // One classified LED, ready for the byte sequencer.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [BYTE_W-1:0]  header;
        logic               start;
        logic               last_led;
        logic [ZERO_W-1:0]  zeros;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/lsfe_led_if.sv]
// Interface for the LED color input channel.
`default_nettype none

interface lsfe_led_if;
    import lsfe_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_led;

    modport source (output valid, output red, output green, output blue,
                    output last_led, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_led, output ready);
endinterface

`default_nettype wire

[rtl/lsfe_byte_if.sv]
// Interface for the serial byte output channel.
`default_nettype none

interface lsfe_byte_if;
    import lsfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_done;

    modport source (output valid, output out_byte, output run_last,
                    output frame_done, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input frame_done, output ready);
endinterface

`default_nettype wire

[rtl/lsfe_cfg_if.sv]
// Interface for the brightness register write channel.
`default_nettype none

interface lsfe_cfg_if;
    import lsfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [BRIGHT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/lsfe_queue.sv]
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module lsfe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsfe_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output lsfe_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import lsfe_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[rtl/lsfe_front.sv]
// Front end: takes LED beats, tracks the LED count and builds sequencer commands.
`default_nettype none

module lsfe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lsfe_led_if.sink       i_led,
    lsfe_cfg_if.sink       i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output lsfe_pkg::t_cmd o_cmd
);
    import lsfe_pkg::*;

    logic [BRIGHT_W-1:0] r_brightness;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    cnt_inc;

    assign i_led.ready = !i_full;
    assign i_cfg.ready = 1'b1;
    assign o_push      = i_led.valid && !i_full;

    // Count after this LED, held at MAX_LEDS once reached.
    assign cnt_inc = (r_count < CNT_W'(MAX_LEDS)) ? r_count + CNT_W'(1) : r_count;
    assign n_count = i_led.last_led ? '0 : cnt_inc;

    always_comb begin
        o_cmd.red      = i_led.red;
        o_cmd.green    = i_led.green;
        o_cmd.blue     = i_led.blue;
        o_cmd.header   = HEADER_MARK | BYTE_W'(r_brightness);
        o_cmd.start    = (r_count == '0);
        o_cmd.last_led = i_led.last_led;
        o_cmd.zeros    = ZERO_W'(END_ZEROS_BASE) + ZERO_W'(cnt_inc / END_ZEROS_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= '1;
            r_count      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_brightness <= i_cfg.data;
            end
            if (o_push) begin
                r_count <= n_count;
            end
        end
    end

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_led.last_led |=> r_count == '0)
        else $error("LED count not cleared after last LED");

endmodule

`default_nettype wire

[rtl/lsfe_back.sv]
// Back end: each command's bytes fill an output register, one per cycle unless stalled.
`default_nettype none

module lsfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lsfe_pkg::t_cmd i_cmd,
    output logic           o_pop,
    lsfe_byte_if.source    o_byte
);
    import lsfe_pkg::*;

    typedef enum logic [2:0] {
        S_NEW, S_START, S_HDR, S_BLUE, S_GREEN, S_RED, S_END, S_ZERO
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_state            cur;
    logic [ZERO_W-1:0] r_cnt;
    logic [ZERO_W-1:0] n_cnt;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_run_last;
    logic              r_frame_done;
    logic [BYTE_W-1:0] n_byte;
    logic              n_run_last;
    logic              n_frame_done;
    logic              adv;
    logic              emit;

    assign adv  = !r_out_valid || o_byte.ready;
    assign emit = adv && i_valid;

    // At the start of a command the first byte depends on whether a start frame leads.
    assign cur = (r_state == S_NEW) ? (i_cmd.start ? S_START : S_HDR) : r_state;

    always_comb begin
        n_state      = cur;
        n_cnt        = r_cnt;
        n_byte       = ZERO_BYTE;
        n_run_last   = 1'b0;
        n_frame_done = 1'b0;
        o_pop        = 1'b0;
        case (cur)
            S_START: begin
                if (r_cnt == ZERO_W'(3)) begin
                    n_state = S_HDR;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + ZERO_W'(1);
                end
            end
            S_HDR: begin
                n_byte  = i_cmd.header;
                n_state = S_BLUE;
            end
            S_BLUE: begin
                n_byte  = i_cmd.blue;
                n_state = S_GREEN;
            end
            S_GREEN: begin
                n_byte  = i_cmd.green;
                n_state = S_RED;
            end
            S_RED: begin
                n_byte = i_cmd.red;
                if (i_cmd.last_led) begin
                    n_state = S_END;
                end else begin
                    n_state    = S_NEW;
                    n_run_last = 1'b1;
                    o_pop      = emit;
                end
            end
            S_END: begin
                n_byte  = END_MARK;
                n_state = S_ZERO;
                n_cnt   = '0;
            end
            S_ZERO: begin
                if (r_cnt == i_cmd.zeros - ZERO_W'(1)) begin
                    n_state      = S_NEW;
                    n_cnt        = '0;
                    n_run_last   = 1'b1;
                    n_frame_done = 1'b1;
                    o_pop        = emit;
                end else begin
                    n_cnt = r_cnt + ZERO_W'(1);
                end
            end
            default: begin
                n_state = S_NEW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_NEW;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_state      <= n_state;
                r_cnt        <= n_cnt;
                r_byte       <= n_byte;
                r_run_last   <= n_run_last;
                r_frame_done <= n_frame_done;
            end
        end
    end

    assign o_byte.valid      = r_out_valid;
    assign o_byte.out_byte   = r_byte;
    assign o_byte.run_last   = r_run_last;
    assign o_byte.frame_done = r_frame_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_done |-> r_run_last)
        else $error("frame_done without run_last");

    a_pop_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_NEW && r_cnt == '0)
        else $error("sequencer did not return to a fresh command after pop");

endmodule

`default_nettype wire

[rtl/led_strip_frame_encoder.sv]
// Top level of the two-wire addressable LED strip frame encoder.
`default_nettype none

// The encoder takes one LED per beat on i_led (red, green, blue and a last_led
// flag) and produces the byte stream for a two-wire LED strip on o_byte, one byte
// per beat. The first LED of a frame is preceded by a start frame of four zero
// bytes. Each LED becomes a header byte (0xE0 OR the brightness register),
// then blue, green and red. After the LED flagged last, an end frame follows:
// 0xFF and then 5 + count/16 zero bytes, where count is the number of LEDs in
// the frame, held at MAX_LEDS once reached. run_last marks the final byte that
// an LED beat causes and frame_done marks the final byte of the end frame.
// The brightness register resets to 31 and is written through i_cfg, whose
// ready is always high; write it only while no LED is in flight.
// Rate: the output side moves one byte per cycle while a command waits and the
// sink is ready. The byte sequencer in the back end sets this rate; a
// two-entry command queue lets the input take the next LED while the
// sequencer still works, and the output register keeps the next byte ready
// while the sink stalls. An accepted LED passes through the command queue
// and the output register before its first byte appears.
module led_strip_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsfe_led_if.sink    i_led,
    lsfe_cfg_if.sink    i_cfg,
    lsfe_byte_if.source o_byte
);
    import lsfe_pkg::*;

    // Commands leaving the front end.
    logic push;
    t_cmd push_cmd;
    logic full;

    // Commands entering the sequencer.
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    // The front end classifies each LED: whether it opens a frame, its header
    // byte and, for the last LED, the length of the end frame's zero run.
    lsfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_led   (i_led),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    lsfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // The sequencer emits the bytes of the head command and pops it with the
    // final byte.
    lsfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

`default_nettype wire
